// ===== hw/rtl/wvms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvms_pkg: shared constants for the wind statistics block
// Arctangent table, fixed-point scale factors and shared-unit operations.
// ----------------------------------------------------------------------------
package wvms_pkg;

    localparam int TABLE_LEN = 24;
    localparam int ZW = 34;   // angle word, Q2.30 plus headroom
    localparam int XW = 40;   // CORDIC x/y word

    localparam logic signed [ZW-1:0] Q30_PER_DEGREE = 34'sd18740330;
    localparam logic signed [XW-1:0] CORDIC_X0 = 40'sd19898;
    localparam logic [28:0] HUNDREDTHS_MUL = 29'd375493621;

    localparam logic [1:0] OP_ROTATE = 2'd0;
    localparam logic [1:0] OP_VECTOR = 2'd1;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0: r = 34'sd843314856;
                5'd1: r = 34'sd497837829;
                5'd2: r = 34'sd263043836;
                5'd3: r = 34'sd133525158;
                5'd4: r = 34'sd67021686;
                5'd5: r = 34'sd33543515;
                5'd6: r = 34'sd16775850;
                5'd7: r = 34'sd8388437;
                5'd8: r = 34'sd4194282;
                5'd9: r = 34'sd2097149;
                5'd10: r = 34'sd1048575;
                5'd11: r = 34'sd524287;
                5'd12: r = 34'sd262143;
                5'd13: r = 34'sd131071;
                5'd14: r = 34'sd65535;
                5'd15: r = 34'sd32767;
                5'd16: r = 34'sd16383;
                5'd17: r = 34'sd8191;
                5'd18: r = 34'sd4095;
                5'd19: r = 34'sd2047;
                5'd20: r = 34'sd1023;
                5'd21: r = 34'sd511;
                5'd22: r = 34'sd255;
                5'd23: r = 34'sd127;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/wvms_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvms_cordic: iterative CORDIC engine
// One micro-rotation a cycle, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
module wvms_cordic
    import wvms_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           op,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic                 done,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);

    localparam int NSTEP = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

    logic                 busy_reg;
    logic [4:0]           step_reg;
    logic [1:0]           op_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic                 pos;
    logic signed [XW-1:0] xs, ys;

    // Arithmetic shift of a signed value already rounds towards minus infinity.
    assign xs  = x_reg >>> step_reg;
    assign ys  = y_reg >>> step_reg;
    assign pos = (op_reg == OP_ROTATE) ? !z_reg[ZW-1] : !y_reg[XW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 5'(NSTEP - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                step_reg <= step_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg <= op;
            x_reg  <= x_in;
            y_reg  <= y_in;
            z_reg  <= z_in;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_ROTATE)
            begin
                x_reg <= pos ? x_reg - ys : x_reg + ys;
                y_reg <= pos ? y_reg + xs : y_reg - xs;
                z_reg <= pos ? z_reg - atan_q30(step_reg) : z_reg + atan_q30(step_reg);
            end
            else
            begin
                x_reg <= pos ? x_reg + ys : x_reg - ys;
                y_reg <= pos ? y_reg - xs : y_reg + xs;
                z_reg <= pos ? z_reg + atan_q30(step_reg) : z_reg - atan_q30(step_reg);
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== hw/rtl/wind_vector_mean_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wind_vector_mean_stats: period statistics of wind samples
// Running extremes, mean speed and vector-mean direction over a period.
// ----------------------------------------------------------------------------
// Usage. Words enter on the valid/ready input channel. A word with kind = 0
// is a wind sample: it updates the period's minima and maxima (the first
// sample seeds them) and, while the count is below MAX_SAMPLES, adds the
// mean speed and the CORDIC sine and cosine of the mean direction to the
// sums; the iterative CORDIC engine rotates the sample's direction first.
// A word with kind = 1 closes the period: the block divides the speed sum
// by the count with a restoring divider, runs the CORDIC in vectoring
// mode, multiplies the angle into hundredths, wraps it and presents one
// result word; when either sum is zero no vectoring is needed and the
// direction comes straight from the signs. An empty period gives its
// result in the cycle after the close is accepted. Ready is low
// throughout this work. The result is held in an output register until
// taken; a stalled receiver keeps the block busy and the next input word
// waits. Reset clears every accumulator and marks the period as awaiting
// its first sample.
// ----------------------------------------------------------------------------
module wind_vector_mean_stats
    import wvms_pkg::*;
#(
    parameter int MAX_SAMPLES  = 255,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [8:0]  dir_min,
    input  logic [8:0]  dir_mean,
    input  logic [8:0]  dir_max,
    input  logic [13:0] speed_min,
    input  logic [13:0] speed_mean,
    input  logic [13:0] speed_max,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] avg_speed,
    output logic [13:0] peak_speed,
    output logic [13:0] low_speed,
    output logic [8:0]  peak_dir,
    output logic [8:0]  low_dir,
    output logic [15:0] vector_dir,
    output logic [7:0]  sample_total,
    output logic        empty_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROT   = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_VEC   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_VWAIT = 4'd9;

    logic [3:0] state_reg;

    // accumulators
    logic [21:0]        speed_sum_reg;
    logic signed [23:0] sine_sum_reg, cosine_sum_reg;
    logic [7:0]         count_reg;
    logic               first_reg;
    logic [8:0]         min_dir_reg, max_dir_reg;
    logic [13:0]        min_spd_reg, max_spd_reg;

    logic               flip_reg;
    logic [13:0]        smean_reg;
    logic [21:0]        quot_reg;
    logic [8:0]         rem_reg;    // remainder is below the 8-bit count
    logic [4:0]         dcnt_reg;
    logic [15:0]        base_reg;
    logic signed [62:0] prod_reg;

    // CORDIC connection
    logic                 c_start, c_done;
    logic [1:0]           c_op;
    logic signed [XW-1:0] c_xi, c_yi, c_xo, c_yo;
    logic signed [ZW-1:0] c_zi, c_zo;

    wvms_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(c_start), .op(c_op),
        .x_in(c_xi), .y_in(c_yi), .z_in(c_zi),
        .done(c_done), .x_out(c_xo), .y_out(c_yo), .z_out(c_zo)
    );

    // Angle reduction to -90..90 degrees for a sample's mean direction.
    logic [8:0]         dmod;
    logic signed [9:0]  dred;
    logic               dflip;
    always_comb
    begin
        dmod  = (dir_mean >= 9'd360) ? dir_mean - 9'd360 : dir_mean;
        dflip = 1'b0;
        if (dmod > 9'd270)
            dred = $signed({1'b0, dmod}) - 10'sd360;
        else if (dmod > 9'd90)
        begin
            dred  = $signed({1'b0, dmod}) - 10'sd180;
            dflip = 1'b1;
        end
        else
            dred = $signed({1'b0, dmod});
    end

    // Vectoring start: sums scaled by 64, folded into the right half plane.
    logic signed [XW-1:0] vx, vy;
    assign vx = XW'(cosine_sum_reg) <<< 6;
    assign vy = XW'(sine_sum_reg) <<< 6;

    logic in_fire;
    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        c_start = 1'b0;
        c_op    = OP_ROTATE;
        c_xi    = CORDIC_X0;
        c_yi    = '0;
        c_zi    = ZW'(dred) * Q30_PER_DEGREE;
        if (in_fire && !kind)
            c_start = 1'b1;
        else if (state_reg == S_VEC)
        begin
            c_start = 1'b1;
            c_op    = OP_VECTOR;
            c_xi    = cosine_sum_reg[23] ? -vx : vx;
            c_yi    = cosine_sum_reg[23] ? -vy : vy;
            c_zi    = '0;
        end
    end

    // Clamp of CORDIC results to Q1.15 and optional negation.
    function automatic logic signed [15:0] sat16(input logic signed [XW-1:0] v);
        begin
            if (v > 40'sd32767)
                return 16'sd32767;
            else if (v < -40'sd32768)
                return -16'sd32768;
            else
                return v[15:0];
        end
    endfunction

    function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
        begin
            return (v == -16'sd32768) ? 16'sd32767 : -v;
        end
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        begin
            if (v > 25'sd8388607)
                return 24'sd8388607;
            else if (v < -25'sd8388608)
                return -24'sd8388608;
            else
                return v[23:0];
        end
    endfunction

    logic signed [15:0] cos_v, sin_v;
    logic [22:0]        sum_ext;
    logic [9:0]         rem_try;
    logic signed [63:0] rnd;
    logic signed [17:0] total;

    always_comb
    begin
        cos_v   = flip_reg ? neg16(sat16(c_xo)) : sat16(c_xo);
        sin_v   = flip_reg ? neg16(sat16(c_yo)) : sat16(c_yo);
        sum_ext = {1'b0, speed_sum_reg} + {9'd0, smean_reg};
        rem_try = {rem_reg, quot_reg[21]} - {2'b0, count_reg};
        rnd     = (64'(prod_reg) + (64'sd1 <<< 45)) >>> 46;
        total   = $signed({2'b0, base_reg}) + 18'(rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid      <= 1'b0;
            speed_sum_reg  <= '0;
            sine_sum_reg   <= '0;
            cosine_sum_reg <= '0;
            count_reg      <= '0;
            first_reg      <= 1'b1;
            min_dir_reg    <= '0;
            max_dir_reg    <= '0;
            min_spd_reg    <= '0;
            max_spd_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && !kind)
                    begin
                        min_dir_reg <= (first_reg || dir_min < min_dir_reg) ? dir_min : min_dir_reg;
                        max_dir_reg <= (first_reg || dir_max > max_dir_reg) ? dir_max : max_dir_reg;
                        min_spd_reg <= (first_reg || speed_min < min_spd_reg) ? speed_min
                                                                               : min_spd_reg;
                        max_spd_reg <= (first_reg || speed_max > max_spd_reg) ? speed_max
                                                                               : max_spd_reg;
                        first_reg <= 1'b0;
                        flip_reg  <= dflip;
                        smean_reg <= speed_mean;
                        state_reg <= S_ROT;
                    end
                    else if (in_fire)
                    begin
                        if (count_reg == 8'd0)
                        begin
                            avg_speed <= '0; peak_speed <= '0; low_speed <= '0;
                            peak_dir <= '0; low_dir <= '0; vector_dir <= '0;
                            sample_total <= '0; empty_res <= 1'b1;
                            out_valid <= 1'b1;
                            state_reg <= S_WAIT;
                        end
                        else
                        begin
                            quot_reg  <= speed_sum_reg;
                            rem_reg   <= '0;
                            dcnt_reg  <= '0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_ROT:
                    if (c_done)
                        state_reg <= S_ACC;
                S_ACC:
                begin
                    if (32'(count_reg) < MAX_SAMPLES)
                    begin
                        speed_sum_reg  <= sum_ext[22] ? '1 : sum_ext[21:0];
                        sine_sum_reg   <= sat24(25'(sine_sum_reg) + 25'(sin_v));
                        cosine_sum_reg <= sat24(25'(cosine_sum_reg) + 25'(cos_v));
                        count_reg      <= count_reg + 8'd1;
                    end
                    state_reg <= S_IDLE;
                end
                S_DIV:
                begin
                    // one restoring step a cycle
                    if (!rem_try[9])
                    begin
                        rem_reg  <= rem_try[8:0];
                        quot_reg <= {quot_reg[20:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= {rem_reg[7:0], quot_reg[21]};
                        quot_reg <= {quot_reg[20:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd21)
                    begin
                        avg_speed    <= '0;
                        peak_speed   <= max_spd_reg;
                        low_speed    <= min_spd_reg;
                        peak_dir     <= max_dir_reg;
                        low_dir      <= min_dir_reg;
                        sample_total <= count_reg;
                        empty_res    <= 1'b0;
                        base_reg     <= cosine_sum_reg[23] ? 16'd18000 : 16'd0;
                        if (cosine_sum_reg == 24'sd0)
                        begin
                            vector_dir <= (sine_sum_reg > 24'sd0) ? 16'd9000 :
                                          (sine_sum_reg < 24'sd0) ? 16'd27000 : 16'd0;
                            state_reg  <= S_FIN;
                        end
                        else if (sine_sum_reg == 24'sd0)
                        begin
                            vector_dir <= cosine_sum_reg[23] ? 16'd18000 : 16'd0;
                            state_reg  <= S_FIN;
                        end
                        else
                            state_reg <= S_VEC;
                    end
                end
                S_VEC:
                    state_reg <= S_VWAIT;
                S_VWAIT:
                    if (c_done)
                    begin
                        prod_reg  <= 63'(c_zo) * $signed({1'b0, HUNDREDTHS_MUL});
                        state_reg <= S_MUL;
                    end
                S_MUL:
                begin
                    if (total < 18'sd0)
                        vector_dir <= 16'(total + 18'sd36000);
                    else if (total >= 18'sd36000)
                        vector_dir <= 16'(total - 18'sd36000);
                    else
                        vector_dir <= total[15:0];
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    avg_speed  <= quot_reg[13:0];
                    out_valid  <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_OUT, S_WAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid      <= 1'b0;
                        speed_sum_reg  <= '0;
                        sine_sum_reg   <= '0;
                        cosine_sum_reg <= '0;
                        count_reg      <= '0;
                        first_reg      <= 1'b1;
                        min_dir_reg    <= '0;
                        max_dir_reg    <= '0;
                        min_spd_reg    <= '0;
                        max_spd_reg    <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // A result is offered only while the block is not taking input.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("result offered while accepting input");

    // The count never passes its limit.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_SAMPLES)
        else $error("sample count beyond limit");

    // An empty flag implies zero count and zero direction in the result.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_res) |-> (sample_total == 8'd0 && vector_dir == 16'd0))
        else $error("empty result carries data");

    // After delivery the period is cleared.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> (count_reg == 8'd0 && first_reg))
        else $error("period not cleared after delivery");

endmodule

// ===== tb/sv/wind_vector_mean_stats_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wind_vector_mean_stats_tb: self-checking bench for the wind statistics block
// Drives wind samples and period closes with random idling on both channels.
// Each close is predicted by a bit-true model of the extremes, the sums, the
// CORDIC sine/cosine and the vector-mean direction, then checked field by field.
// ----------------------------------------------------------------------------
module wind_vector_mean_stats_tb
    import wvms_pkg::*;
;

    localparam int MAX_SAMPLES  = 255;
    localparam int CORDIC_STEPS = 16;
    localparam int STALL_LIMIT  = 20000;

    // Kinds of input word.
    typedef enum logic {KIND_SAMPLE = 1'b0, KIND_CLOSE = 1'b1} word_kind_t;

    // One period summary as the block reports it.
    typedef struct packed {
        logic [13:0] avg_speed;
        logic [13:0] peak_speed;
        logic [13:0] low_speed;
        logic [8:0]  peak_dir;
        logic [8:0]  low_dir;
        logic [15:0] vector_dir;
        logic [7:0]  sample_total;
        logic        empty_res;
    } summary_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [8:0]  dir_min;
    logic [8:0]  dir_mean;
    logic [8:0]  dir_max;
    logic [13:0] speed_min;
    logic [13:0] speed_mean;
    logic [13:0] speed_max;
    logic        out_valid;
    logic        out_ready;
    logic [13:0] avg_speed;
    logic [13:0] peak_speed;
    logic [13:0] low_speed;
    logic [8:0]  peak_dir;
    logic [8:0]  low_dir;
    logic [15:0] vector_dir;
    logic [7:0]  sample_total;
    logic        empty_res;

    // Period state of the prediction, mirroring the block's accumulators.
    logic [21:0]        p_speed_sum;
    logic signed [23:0] p_sine_sum;
    logic signed [23:0] p_cosine_sum;
    logic [7:0]         p_count;
    logic               p_first;
    logic [8:0]         p_min_dir;
    logic [8:0]         p_max_dir;
    logic [13:0]        p_min_speed;
    logic [13:0]        p_max_speed;

    summary_t summaries_due[$];

    int  errors = 0;
    int  words_sent = 0;
    int  closes_seen = 0;
    int  idle_pct = 34;      // chance in a hundred that either side idles
    bit  hold_off = 0;       // the receiver's long back-pressure stretch
    int  quiet_cycles = 0;

    wind_vector_mean_stats #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .dir_min      (dir_min),
        .dir_mean     (dir_mean),
        .dir_max      (dir_max),
        .speed_min    (speed_min),
        .speed_mean   (speed_mean),
        .speed_max    (speed_max),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .avg_speed    (avg_speed),
        .peak_speed   (peak_speed),
        .low_speed    (low_speed),
        .peak_dir     (peak_dir),
        .low_dir      (low_dir),
        .vector_dir   (vector_dir),
        .sample_total (sample_total),
        .empty_res    (empty_res)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Shift of a signed value, rounding towards minus infinity.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint arctan_step(int i);
        return longint'(atan_q30(5'(i)));
    endfunction

    // Sine and cosine in Q1.15 of a whole-degree angle, by CORDIC rotation.
    task automatic rotate_degrees(input logic [8:0] deg, output longint s,
                                  output longint c);
        longint d;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit flip;
        d = longint'(deg) % 360;
        flip = 0;
        x = longint'(CORDIC_X0);
        y = 0;
        if (d > 270)
        begin
            d = d - 360;
        end
        else if (d > 90)
        begin
            d = d - 180;
            flip = 1;
        end
        z = d * longint'(Q30_PER_DEGREE);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z  = z - arctan_step(i);
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z  = z + arctan_step(i);
            end
            x = nx;
        end
        x = clamp(x, -32768, 32767);
        y = clamp(y, -32768, 32767);
        if (flip)
        begin
            x = clamp(-x, -32768, 32767);
            y = clamp(-y, -32768, 32767);
        end
        s = y;
        c = x;
    endtask

    // Direction of the summed vector in hundredths of a degree, 0 to 35999.
    function automatic logic [15:0] heading_hundredths(longint s, longint c);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint total;
        longint base;
        z = 0;
        base = 0;
        if (c == 0)
        begin
            return s > 0 ? 16'd9000 : (s < 0 ? 16'd27000 : 16'd0);
        end
        if (s == 0)
        begin
            return c > 0 ? 16'd0 : 16'd18000;
        end
        x = c * 64;
        y = s * 64;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            base = 18000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z  = z + arctan_step(i);
            end
            else
            begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z  = z - arctan_step(i);
            end
            x = nx;
        end
        total = base + floor_shift(z * longint'(HUNDREDTHS_MUL) + (longint'(1) << 45), 46);
        while (total < 0)
        begin
            total = total + 36000;
        end
        while (total >= 36000)
        begin
            total = total - 36000;
        end
        return 16'(total);
    endfunction

    function automatic void clear_period();
        p_speed_sum  = '0;
        p_sine_sum   = '0;
        p_cosine_sum = '0;
        p_count      = '0;
        p_first      = 1'b1;
        p_min_dir    = '0;
        p_max_dir    = '0;
        p_min_speed  = '0;
        p_max_speed  = '0;
    endfunction

    // Advances the predicted period by one accepted word and queues the
    // summary that a close word must produce.
    task automatic predict_word(input word_kind_t k, input logic [8:0] dmin,
                                input logic [8:0] dmean, input logic [8:0] dmax,
                                input logic [13:0] smin, input logic [13:0] smean,
                                input logic [13:0] smax);
        longint sv;
        longint cv;
        longint sum;
        summary_t r;
        if (k == KIND_SAMPLE)
        begin
            if (p_first)
            begin
                p_min_dir   = dmin;
                p_max_dir   = dmax;
                p_min_speed = smin;
                p_max_speed = smax;
                p_first     = 1'b0;
            end
            if (dmin < p_min_dir) p_min_dir = dmin;
            if (dmax > p_max_dir) p_max_dir = dmax;
            if (smin < p_min_speed) p_min_speed = smin;
            if (smax > p_max_speed) p_max_speed = smax;
            // Once the count saturates only the extremes move on.
            if (p_count < MAX_SAMPLES)
            begin
                sum = longint'(p_speed_sum) + longint'(smean);
                p_speed_sum = 22'(clamp(sum, 0, 22'h3FFFFF));
                rotate_degrees(dmean, sv, cv);
                p_sine_sum   = 24'(clamp(longint'(p_sine_sum) + sv, -8388608, 8388607));
                p_cosine_sum = 24'(clamp(longint'(p_cosine_sum) + cv, -8388608, 8388607));
                p_count++;
            end
        end
        else
        begin
            r = '0;
            if (p_count == 0)
            begin
                r.empty_res = 1'b1;
            end
            else
            begin
                r.avg_speed    = 14'(p_speed_sum / p_count);
                r.peak_speed   = p_max_speed;
                r.low_speed    = p_min_speed;
                r.peak_dir     = p_max_dir;
                r.low_dir      = p_min_dir;
                r.vector_dir   = heading_hundredths(p_sine_sum, p_cosine_sum);
                r.sample_total = p_count;
            end
            summaries_due.push_back(r);
            clear_period();
        end
    endtask

    // Offers one word, sometimes after a random gap, and waits for its acceptance.
    // Valid stays high between back-to-back words.
    task automatic send_word(input word_kind_t k, input logic [8:0] dmin,
                             input logic [8:0] dmean, input logic [8:0] dmax,
                             input logic [13:0] smin, input logic [13:0] smean,
                             input logic [13:0] smax);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        dir_min    <= dmin;
        dir_mean   <= dmean;
        dir_max    <= dmax;
        speed_min  <= smin;
        speed_mean <= smean;
        speed_max  <= smax;
        do
        begin
            @(posedge clk);
        end while (!in_ready);
        predict_word(k, dmin, dmean, dmax, smin, smean, smax);
        words_sent++;
    endtask

    task automatic send_sample(input logic [8:0] dmin, input logic [8:0] dmean,
                               input logic [8:0] dmax, input logic [13:0] smin,
                               input logic [13:0] smean, input logic [13:0] smax);
        send_word(KIND_SAMPLE, dmin, dmean, dmax, smin, smean, smax);
    endtask

    task automatic send_close();
        send_word(KIND_CLOSE, 9'($urandom), 9'($urandom), 9'($urandom),
                  14'($urandom), 14'($urandom), 14'($urandom));
    endtask

    // A fully random sample, any 9- and 14-bit value.
    task automatic send_noise_sample();
        send_sample(9'($urandom), 9'($urandom), 9'($urandom),
                    14'($urandom), 14'($urandom), 14'($urandom));
    endtask

    // A plausible sample inside the field ranges, ordered min <= mean <= max.
    task automatic send_plausible_sample(input int centre, input int spread);
        int   d;
        int   sp;
        logic [8:0] dm;
        d  = (centre + $urandom_range(0, 2 * spread) - spread + 360) % 360;
        sp = $urandom_range(0, 9999);
        dm = 9'(d);
        send_sample(9'($urandom_range(0, d)), dm, 9'($urandom_range(d, 359)),
                    14'($urandom_range(0, sp)), 14'(sp), 14'($urandom_range(sp, 9999)));
    endtask

    // Directed: an empty period, extremes of every field and the axes.
    task automatic test_directed_edges();
        send_close();
        send_sample(9'd0, 9'd0, 9'd0, 14'd0, 14'd0, 14'd0);
        send_close();
        send_sample(9'd359, 9'd359, 9'd359, 14'd9999, 14'd9999, 14'd9999);
        send_sample(9'd511, 9'd511, 9'd511, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        send_close();
        // Opposite directions cancel: zero sums in one or both axes.
        send_sample(9'd10, 9'd90, 9'd100, 14'd5, 14'd50, 14'd60);
        send_sample(9'd200, 9'd270, 9'd300, 14'd1, 14'd20, 14'd90);
        send_close();
        send_sample(9'd0, 9'd180, 9'd0, 14'd1, 14'd1, 14'd1);
        send_close();
        send_sample(9'd0, 9'd90, 9'd0, 14'd1, 14'd1, 14'd1);
        send_close();
        send_sample(9'd0, 9'd270, 9'd0, 14'd1, 14'd1, 14'd1);
        send_close();
        send_sample(9'd0, 9'd45, 9'd0, 14'd3, 14'd3, 14'd3);
        send_sample(9'd0, 9'd135, 9'd0, 14'd3, 14'd4, 14'd3);
        send_sample(9'd0, 9'd225, 9'd0, 14'd3, 14'd5, 14'd3);
        send_close();
        send_sample(9'd1, 9'd1, 9'd1, 14'd2, 14'd2, 14'd2);
        send_sample(9'd359, 9'd359, 9'd359, 14'd2, 14'd2, 14'd2);
        send_close();
        send_close();
    endtask

    // Count saturation and extremes after saturation.
    task automatic test_saturation();
        for (int n = 0; n < MAX_SAMPLES + 12; n++)
        begin
            if (n == MAX_SAMPLES + 5)
            begin
                send_sample(9'd0, 9'd90, 9'd511, 14'd0, 14'h3FFF, 14'h3FFF);
            end
            else
            begin
                send_sample(9'd100, 9'd90, 9'd100, 14'h3FFF, 14'h3FFF, 14'h3FFF);
            end
        end
        send_close();
    endtask

    // Random periods of mostly plausible samples, with some noise.
    task automatic test_random_periods(input int words);
        int sent;
        int len;
        int centre;
        int spread;
        sent = 0;
        while (sent < words)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
            centre = $urandom_range(0, 359);
            spread = $urandom_range(0, 180);
            for (int n = 0; n < len; n++)
            begin
                if ($urandom_range(9) < 2)
                begin
                    send_noise_sample();
                end
                else
                begin
                    send_plausible_sample(centre, spread);
                end
            end
            send_close();
            sent = sent + len + 1;
        end
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        hold_off = 1;
        fork
            begin
                repeat (3)
                begin
                    send_plausible_sample(0, 180);
                    send_close();
                end
            end
            begin
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
        join
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        // The last word has been taken; nothing more is offered.
        in_valid <= 1'b0;
        while (summaries_due.size() != 0 && guard < STALL_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4 * CORDIC_STEPS + 80) @(posedge clk);
    endtask

    // Receiver readiness: random idling, a hold-off stretch when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
        end
    end

    // Result checker: compares every accepted summary with the oldest due.
    always @(posedge clk)
    begin
        summary_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (summaries_due.size() == 0)
            begin
                $error("unexpected summary word, vector_dir %0d", vector_dir);
                errors++;
            end
            else
            begin
                want = summaries_due.pop_front();
                closes_seen++;
                if (avg_speed !== want.avg_speed)
                begin
                    $error("avg_speed: expected %0d, got %0d", want.avg_speed, avg_speed);
                    errors++;
                end
                if (peak_speed !== want.peak_speed)
                begin
                    $error("peak_speed: expected %0d, got %0d", want.peak_speed, peak_speed);
                    errors++;
                end
                if (low_speed !== want.low_speed)
                begin
                    $error("low_speed: expected %0d, got %0d", want.low_speed, low_speed);
                    errors++;
                end
                if (peak_dir !== want.peak_dir)
                begin
                    $error("peak_dir: expected %0d, got %0d", want.peak_dir, peak_dir);
                    errors++;
                end
                if (low_dir !== want.low_dir)
                begin
                    $error("low_dir: expected %0d, got %0d", want.low_dir, low_dir);
                    errors++;
                end
                if (vector_dir !== want.vector_dir)
                begin
                    $error("vector_dir: expected %0d, got %0d", want.vector_dir, vector_dir);
                    errors++;
                end
                if (sample_total !== want.sample_total)
                begin
                    $error("sample_total: expected %0d, got %0d",
                           want.sample_total, sample_total);
                    errors++;
                end
                if (empty_res !== want.empty_res)
                begin
                    $error("empty_res: expected %0d, got %0d", want.empty_res, empty_res);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no word moving on either side
    // means the block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("wind_vector_mean_stats_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_SAMPLE;
        dir_min    = '0;
        dir_mean   = '0;
        dir_max    = '0;
        speed_min  = '0;
        speed_mean = '0;
        speed_max  = '0;
        clear_period();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_saturation();
        test_backpressure();
        // A stretch with no idling at all on either side.
        idle_pct = 0;
        test_random_periods(250);
        idle_pct = 34;
        test_random_periods(850);
        drain();

        if (summaries_due.size() != 0)
        begin
            $error("%0d summaries never arrived", summaries_due.size());
            errors++;
        end
        $display("Covered %0d words and %0d period summaries, including empty and",
                 words_sent, closes_seen);
        $display("saturated periods, cancelling vectors and a long receiver stall.");
        if (errors == 0)
        begin
            $display("wind_vector_mean_stats_tb: PASS");
        end
        else
        begin
            $display("wind_vector_mean_stats_tb: FAIL");
        end
        $finish;
    end

endmodule
